// ===== rtl/core/gamepad_edge_repeat_qualifier_macros.svh =====
// Assertion macros for the gamepad edge and repeat qualifier.
// Included by gamepad_edge_repeat_qualifier.sv, the RTL file that carries concurrent assertions; no other dependencies.
`ifndef GAMEPAD_EDGE_REPEAT_QUALIFIER_MACROS_SVH
`define GAMEPAD_EDGE_REPEAT_QUALIFIER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GERQ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GERQ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/gerq_pkg.sv =====
// Package for the gamepad edge and repeat qualifier: widths, reset values,
// register indexes and direction codes. No dependencies.
`default_nettype none

package gerq_pkg;

   // Field widths
   localparam int ButtonW    = 16;
   localparam int AxisW      = 16;
   localparam int TimeW      = 32;
   localparam int DeadZoneW  = 15;
   localparam int IntervalW  = 16;
   localparam int ThresholdW = 16;
   localparam int CsrDataW   = 16;
   localparam int CsrIndexW  = 2;

   // Sticks and direction slots
   localparam int StickCount   = 2;
   localparam int AxisPairs    = 2;
   localparam int DirsPerStick = 4;
   localparam int DirSlots     = 8;

   // Direction bit positions within one stick
   localparam int DirUp    = 0;
   localparam int DirDown  = 1;
   localparam int DirLeft  = 2;
   localparam int DirRight = 3;

   // D-pad bits that the left stick sets in the button word
   localparam logic [ButtonW-1:0] PadUp    = 16'h0001;
   localparam logic [ButtonW-1:0] PadDown  = 16'h0002;
   localparam logic [ButtonW-1:0] PadLeft  = 16'h0004;
   localparam logic [ButtonW-1:0] PadRight = 16'h0008;

   // Register reset values
   localparam logic [DeadZoneW-1:0]  DeadZoneReset  = 15'd7849;
   localparam logic [IntervalW-1:0]  IntervalReset  = 16'd15;
   localparam logic [ThresholdW-1:0] ThresholdReset = 16'd3276;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_DEAD_ZONE       = 2'd0,
      CSR_REPEAT_INTERVAL = 2'd1,
      CSR_STICK_THRESHOLD = 2'd2
   } csr_index_type;

   // Time reference shared by all repeat timers
   typedef struct packed {
      logic [TimeW-1:0]     now_ms;
      logic [IntervalW-1:0] interval;
   } time_ref_type;

endpackage

`default_nettype wire

// ===== rtl/core/gerq_if.sv =====
// Valid/ready channel interfaces for the poll input and the result output.
// Depends on gerq_pkg for field widths.
`default_nettype none

interface gerq_req_if;
   logic                                valid;
   logic                                ready;
   logic                                connected;
   logic [gerq_pkg::ButtonW-1:0]        buttons;
   logic signed [gerq_pkg::AxisW-1:0]   left_x;
   logic signed [gerq_pkg::AxisW-1:0]   left_y;
   logic signed [gerq_pkg::AxisW-1:0]   right_x;
   logic signed [gerq_pkg::AxisW-1:0]   right_y;
   logic [gerq_pkg::TimeW-1:0]          now_ms;

   modport source (
      output valid, connected, buttons, left_x, left_y, right_x, right_y, now_ms,
      input  ready
   );
   modport sink (
      input  valid, connected, buttons, left_x, left_y, right_x, right_y, now_ms,
      output ready
   );
endinterface

interface gerq_rsp_if;
   logic                                        valid;
   logic                                        ready;
   logic                                        pad_present;
   logic [gerq_pkg::ButtonW-1:0]                button_press;
   logic [gerq_pkg::ButtonW-1:0]                button_rise;
   logic [gerq_pkg::ButtonW-1:0]                button_fall;
   logic [gerq_pkg::ButtonW-1:0]                button_repeat;
   logic [gerq_pkg::DirSlots-1:0]               stick_press;
   logic [gerq_pkg::DirSlots-1:0]               stick_rise;
   logic [gerq_pkg::DirSlots-1:0]               stick_fall;
   logic [gerq_pkg::DirSlots-1:0]               stick_repeat;

   modport source (
      output valid, pad_present, button_press, button_rise, button_fall, button_repeat,
             stick_press, stick_rise, stick_fall, stick_repeat,
      input  ready
   );
   modport sink (
      input  valid, pad_present, button_press, button_rise, button_fall, button_repeat,
             stick_press, stick_rise, stick_fall, stick_repeat,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/gerq_stick_dir.sv =====
// Sorts one stick into up, down, left or right by its dominant axis.
// Depends on gerq_pkg for widths and direction bit positions.
`default_nettype none

module gerq_stick_dir (
   input  logic signed [gerq_pkg::AxisW-1:0]      axis_x,
   input  logic signed [gerq_pkg::AxisW-1:0]      axis_y,
   input  logic [gerq_pkg::ThresholdW-1:0]        threshold,
   output logic [gerq_pkg::DirsPerStick-1:0]      dir
);

   logic [gerq_pkg::AxisW:0] mag_x;
   logic [gerq_pkg::AxisW:0] mag_y;
   logic [gerq_pkg::AxisW:0] mag_max;
   logic                     over;

   // Magnitudes carry one extra bit so that the most negative value fits.
   assign mag_x   = axis_x[gerq_pkg::AxisW-1] ? ({(gerq_pkg::AxisW+1){1'b0}} - {axis_x[gerq_pkg::AxisW-1], axis_x})
                                             : {1'b0, axis_x};
   assign mag_y   = axis_y[gerq_pkg::AxisW-1] ? ({(gerq_pkg::AxisW+1){1'b0}} - {axis_y[gerq_pkg::AxisW-1], axis_y})
                                             : {1'b0, axis_y};
   assign mag_max = (mag_x > mag_y) ? mag_x : mag_y;
   assign over    = mag_max > {1'b0, threshold};

   always_comb begin
      dir = '0;
      priority if (!over) begin
         dir = '0;
      end else if (mag_y > mag_x) begin
         if (!axis_y[gerq_pkg::AxisW-1]) dir[gerq_pkg::DirUp] = 1'b1;
         else dir[gerq_pkg::DirDown] = 1'b1;
      end else if (mag_x > mag_y) begin
         if (!axis_x[gerq_pkg::AxisW-1]) dir[gerq_pkg::DirRight] = 1'b1;
         else dir[gerq_pkg::DirLeft] = 1'b1;
      end else begin
         // An exact diagonal selects no direction.
         dir = '0;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gerq_repeat_lane.sv =====
// One auto-repeat timer: fires when active and the wrapped elapsed time exceeds
// the interval, then restarts from the current time. Depends on gerq_pkg.
`default_nettype none

module gerq_repeat_lane (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       advance,
   input  logic                       active,
   input  gerq_pkg::time_ref_type     time_ref,
   output logic                       fire
);

   logic [gerq_pkg::TimeW-1:0] last_ff;
   logic [gerq_pkg::TimeW-1:0] last_in;
   logic [gerq_pkg::TimeW-1:0] elapsed;

   assign elapsed = time_ref.now_ms - last_ff;
   assign fire    = active
                    && (elapsed > {{(gerq_pkg::TimeW-gerq_pkg::IntervalW){1'b0}}, time_ref.interval});
   assign last_in = (advance && fire) ? time_ref.now_ms : last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else begin
         last_ff <= last_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/gamepad_edge_repeat_qualifier.sv =====
// A transaction accepted into the input register reaches rsp_chan from the result register.
// Throughput: one transaction per cycle, set by the single compute step between the
// input register and the result register; while a result waits, both registers hold
// and the request channel stalls as soon as the input register is full.
// Reset (synchronous, active high) empties both stages, clears edge history and repeat
// timers, and loads the configuration registers with their documented defaults.
`default_nettype none
`include "gamepad_edge_repeat_qualifier_macros.svh"

module gamepad_edge_repeat_qualifier (
   input  logic                               clock,
   input  logic                               reset,
   gerq_req_if.sink                           req_chan,
   gerq_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [gerq_pkg::CsrIndexW-1:0]     csr_index,
   input  logic [gerq_pkg::CsrDataW-1:0]      csr_wdata
);

   // ------------------------------------------------------------------
   // Configuration registers; the compute step reads them directly.
   // Software must write them only while the block is idle (unchecked).
   // ------------------------------------------------------------------
   logic [gerq_pkg::DeadZoneW-1:0]  dead_zone_ff;
   logic [gerq_pkg::IntervalW-1:0]  repeat_interval_ff;
   logic [gerq_pkg::ThresholdW-1:0] stick_threshold_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff       <= gerq_pkg::DeadZoneReset;
         repeat_interval_ff <= gerq_pkg::IntervalReset;
         stick_threshold_ff <= gerq_pkg::ThresholdReset;
      end else if (csr_we) begin
         unique case (csr_index)
            gerq_pkg::CSR_DEAD_ZONE:
               dead_zone_ff <= csr_wdata[gerq_pkg::DeadZoneW-1:0];
            gerq_pkg::CSR_REPEAT_INTERVAL:
               repeat_interval_ff <= csr_wdata[gerq_pkg::IntervalW-1:0];
            gerq_pkg::CSR_STICK_THRESHOLD:
               stick_threshold_ff <= csr_wdata[gerq_pkg::ThresholdW-1:0];
            default: begin
               // Writes to unused indexes are dropped.
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Input register. It takes a new transaction whenever it is empty or
   // its current contents move on to the result register in this cycle.
   // ------------------------------------------------------------------
   logic                                in_valid_ff;
   logic                                in_connected_ff;
   logic [gerq_pkg::ButtonW-1:0]        in_buttons_ff;
   logic signed [gerq_pkg::AxisW-1:0]   in_left_x_ff;
   logic signed [gerq_pkg::AxisW-1:0]   in_left_y_ff;
   logic signed [gerq_pkg::AxisW-1:0]   in_right_x_ff;
   logic signed [gerq_pkg::AxisW-1:0]   in_right_y_ff;
   logic [gerq_pkg::TimeW-1:0]          in_now_ms_ff;

   logic rsp_valid_ff;
   logic advance;
   logic req_accept;

   // The compute step fires when the input register holds a poll and the
   // result register is free or being emptied at this edge.
   assign advance        = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_accept     = req_chan.valid && req_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         in_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_connected_ff <= req_chan.connected;
         in_buttons_ff   <= req_chan.buttons;
         in_left_x_ff    <= req_chan.left_x;
         in_left_y_ff    <= req_chan.left_y;
         in_right_x_ff   <= req_chan.right_x;
         in_right_y_ff   <= req_chan.right_y;
         in_now_ms_ff    <= req_chan.now_ms;
      end
   end

   // ------------------------------------------------------------------
   // Stick directions. Each stick with axes gets its own classifier; any
   // direction slots beyond the configured stick count stay inactive.
   // ------------------------------------------------------------------
   logic signed [gerq_pkg::AxisW-1:0] axis_x [gerq_pkg::AxisPairs];
   logic signed [gerq_pkg::AxisW-1:0] axis_y [gerq_pkg::AxisPairs];
   logic [gerq_pkg::DirSlots-1:0]     dirs_raw;
   logic [gerq_pkg::DirSlots-1:0]     dirs;

   assign axis_x[0] = in_left_x_ff;
   assign axis_y[0] = in_left_y_ff;
   assign axis_x[1] = in_right_x_ff;
   assign axis_y[1] = in_right_y_ff;

   for (genvar s = 0; s < gerq_pkg::AxisPairs; s++) begin : g_stick
      if (s < gerq_pkg::StickCount) begin : g_used
         gerq_stick_dir u_stick_dir (
            .axis_x    (axis_x[s]),
            .axis_y    (axis_y[s]),
            .threshold (stick_threshold_ff),
            .dir       (dirs_raw[s*gerq_pkg::DirsPerStick +: gerq_pkg::DirsPerStick])
         );
      end else begin : g_unused
         assign dirs_raw[s*gerq_pkg::DirsPerStick +: gerq_pkg::DirsPerStick] = '0;
      end
   end

   // A disconnected poll shows no directions at all.
   assign dirs = in_connected_ff ? dirs_raw : '0;

   // ------------------------------------------------------------------
   // Button word with the left stick's dead-zone crossings as d-pad bits.
   // The comparisons are signed and one bit wider than the axes, so that
   // the negated dead zone always fits.
   // ------------------------------------------------------------------
   logic signed [gerq_pkg::AxisW:0]  dz_pos;
   logic signed [gerq_pkg::AxisW:0]  dz_neg;
   logic signed [gerq_pkg::AxisW:0]  lx_ext;
   logic signed [gerq_pkg::AxisW:0]  ly_ext;
   logic [gerq_pkg::ButtonW-1:0]     dpad_word;
   logic [gerq_pkg::ButtonW-1:0]     button_word;

   assign dz_pos = signed'({{(gerq_pkg::AxisW+1-gerq_pkg::DeadZoneW){1'b0}}, dead_zone_ff});
   assign dz_neg = -dz_pos;
   assign lx_ext = signed'({in_left_x_ff[gerq_pkg::AxisW-1], in_left_x_ff});
   assign ly_ext = signed'({in_left_y_ff[gerq_pkg::AxisW-1], in_left_y_ff});

   always_comb begin
      dpad_word = '0;
      priority if (ly_ext >= dz_pos) dpad_word = dpad_word | gerq_pkg::PadUp;
      else if (ly_ext <= dz_neg) dpad_word = dpad_word | gerq_pkg::PadDown;
      else dpad_word = dpad_word;
      priority if (lx_ext <= dz_neg) dpad_word = dpad_word | gerq_pkg::PadLeft;
      else if (lx_ext >= dz_pos) dpad_word = dpad_word | gerq_pkg::PadRight;
      else dpad_word = dpad_word;
   end

   assign button_word = in_buttons_ff | dpad_word;

   // ------------------------------------------------------------------
   // Repeat timers: one for the whole button word and one per direction
   // slot. Each only restarts when its own pulse fires in a compute step.
   // ------------------------------------------------------------------
   gerq_pkg::time_ref_type        time_ref;
   logic                          button_fire;
   logic [gerq_pkg::DirSlots-1:0] dir_fire;

   assign time_ref.now_ms   = in_now_ms_ff;
   assign time_ref.interval = repeat_interval_ff;

   gerq_repeat_lane u_button_lane (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .active   (in_connected_ff && (button_word != '0)),
      .time_ref (time_ref),
      .fire     (button_fire)
   );

   for (genvar d = 0; d < gerq_pkg::DirSlots; d++) begin : g_dir_lane
      gerq_repeat_lane u_dir_lane (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .active   (dirs[d]),
         .time_ref (time_ref),
         .fire     (dir_fire[d])
      );
   end

   // ------------------------------------------------------------------
   // Edge history. It moves only on connected polls, so a dropped poll
   // leaves the previous words untouched.
   // ------------------------------------------------------------------
   logic [gerq_pkg::ButtonW-1:0]  prev_button_ff;
   logic [gerq_pkg::ButtonW-1:0]  prev_button_in;
   logic [gerq_pkg::DirSlots-1:0] prev_dirs_ff;
   logic [gerq_pkg::DirSlots-1:0] prev_dirs_in;
   logic                          history_load;

   assign history_load   = advance && in_connected_ff;
   assign prev_button_in = history_load ? button_word : prev_button_ff;
   assign prev_dirs_in   = history_load ? dirs : prev_dirs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_button_ff <= '0;
         prev_dirs_ff   <= '0;
      end else begin
         prev_button_ff <= prev_button_in;
         prev_dirs_ff   <= prev_dirs_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register. Every field is forced to zero for a disconnected
   // poll; pad_present simply echoes the connected flag.
   // ------------------------------------------------------------------
   logic                          rsp_present_ff;
   logic [gerq_pkg::ButtonW-1:0]  rsp_press_ff;
   logic [gerq_pkg::ButtonW-1:0]  rsp_rise_ff;
   logic [gerq_pkg::ButtonW-1:0]  rsp_fall_ff;
   logic [gerq_pkg::ButtonW-1:0]  rsp_repeat_ff;
   logic [gerq_pkg::DirSlots-1:0] rsp_stick_press_ff;
   logic [gerq_pkg::DirSlots-1:0] rsp_stick_rise_ff;
   logic [gerq_pkg::DirSlots-1:0] rsp_stick_fall_ff;
   logic [gerq_pkg::DirSlots-1:0] rsp_stick_repeat_ff;

   logic [gerq_pkg::ButtonW-1:0]  press_in;
   logic [gerq_pkg::ButtonW-1:0]  rise_in;
   logic [gerq_pkg::ButtonW-1:0]  fall_in;
   logic [gerq_pkg::ButtonW-1:0]  repeat_in;

   assign press_in  = in_connected_ff ? button_word : '0;
   assign rise_in   = in_connected_ff ? (button_word & ~prev_button_ff) : '0;
   assign fall_in   = in_connected_ff ? (~button_word & prev_button_ff) : '0;
   assign repeat_in = button_fire ? button_word : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_chan.ready) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_present_ff      <= in_connected_ff;
         rsp_press_ff        <= press_in;
         rsp_rise_ff         <= rise_in;
         rsp_fall_ff         <= fall_in;
         rsp_repeat_ff       <= repeat_in;
         rsp_stick_press_ff  <= dirs;
         rsp_stick_rise_ff   <= in_connected_ff ? (dirs & ~prev_dirs_ff) : '0;
         rsp_stick_fall_ff   <= in_connected_ff ? (~dirs & prev_dirs_ff) : '0;
         rsp_stick_repeat_ff <= dir_fire;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pad_present   = rsp_present_ff;
   assign rsp_chan.button_press  = rsp_press_ff;
   assign rsp_chan.button_rise   = rsp_rise_ff;
   assign rsp_chan.button_fall   = rsp_fall_ff;
   assign rsp_chan.button_repeat = rsp_repeat_ff;
   assign rsp_chan.stick_press   = rsp_stick_press_ff;
   assign rsp_chan.stick_rise    = rsp_stick_rise_ff;
   assign rsp_chan.stick_fall    = rsp_stick_fall_ff;
   assign rsp_chan.stick_repeat  = rsp_stick_repeat_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------

   // A disconnected poll must give an all-zero result.
   `GERQ_ASSERT_NOW(a_absent_zero, rsp_valid_ff && !rsp_present_ff, (rsp_press_ff == '0) && (rsp_rise_ff == '0) && (rsp_fall_ff == '0) && (rsp_repeat_ff == '0) && (rsp_stick_press_ff == '0) && (rsp_stick_repeat_ff == '0), "disconnected poll gave a non-zero result")

   // A stick shows at most one direction at a time.
   `GERQ_ASSERT_NOW(a_one_dir, rsp_valid_ff, $onehot0(rsp_stick_press_ff[3:0]) && $onehot0(rsp_stick_press_ff[7:4]), "stick shows more than one direction")

   // Repeat pulses only appear on bits that are held.
   `GERQ_ASSERT_NOW(a_repeat_held, rsp_valid_ff, ((rsp_repeat_ff & ~rsp_press_ff) == '0) && ((rsp_stick_repeat_ff & ~rsp_stick_press_ff) == '0), "repeat pulse on a bit that is not held")

   // A connected poll that completes becomes the edge history for the next one.
   `GERQ_ASSERT_NEXT(a_history, history_load, (prev_button_ff == $past(button_word)) && (prev_dirs_ff == $past(dirs)), "edge history did not follow the last connected poll")

endmodule

`default_nettype wire

// ===== dv/gamepad_edge_repeat_qualifier_test.sv =====
// Self-checking testbench for the gamepad edge and repeat qualifier: directed polls from a
// table, then random polls over several register settings, checked against a local predictor.
// Depends on gerq_pkg and the gerq_req_if / gerq_rsp_if interfaces from the RTL.
`default_nettype none

module gamepad_edge_repeat_qualifier_test;
   timeunit 1ns;
   timeprecision 1ps;

   // One poll of the pad, in the order the request channel carries it.
   typedef struct packed {
      logic                               connected;
      logic [gerq_pkg::ButtonW-1:0]       buttons;
      logic signed [gerq_pkg::AxisW-1:0]  left_x;
      logic signed [gerq_pkg::AxisW-1:0]  left_y;
      logic signed [gerq_pkg::AxisW-1:0]  right_x;
      logic signed [gerq_pkg::AxisW-1:0]  right_y;
      logic [gerq_pkg::TimeW-1:0]         now_ms;
   } poll_type;

   // One qualified report, in the order the result channel carries it.
   typedef struct packed {
      logic                          pad_present;
      logic [gerq_pkg::ButtonW-1:0]  button_press;
      logic [gerq_pkg::ButtonW-1:0]  button_rise;
      logic [gerq_pkg::ButtonW-1:0]  button_fall;
      logic [gerq_pkg::ButtonW-1:0]  button_repeat;
      logic [gerq_pkg::DirSlots-1:0] stick_press;
      logic [gerq_pkg::DirSlots-1:0] stick_rise;
      logic [gerq_pkg::DirSlots-1:0] stick_fall;
      logic [gerq_pkg::DirSlots-1:0] stick_repeat;
   } report_type;

   // A directed row: the poll, and where it is obvious, the report typed in by hand.
   typedef struct packed {
      poll_type   poll;
      logic       typed;
      report_type report;
   } directed_row_type;

   localparam int RandomPollsPerPhase = 215;
   localparam int PhaseCount          = 8;
   localparam int LongHoldCycles      = 64;
   // The longest quiet stretch in a correct run is the long hold of the receiver, so this
   // limit is many times that.
   localparam int StallLimit          = 4000;
   localparam int TailCycles          = 10;

   localparam report_type NoReport = '0;

   // Directed polls, run straight after reset with the default register values
   // (dead zone 7849, repeat interval 15 ms, stick threshold 3276).
   localparam directed_row_type DirectedRows [20] = '{
      // Disconnected with every field at an extreme: all outputs are zero.
      '{'{1'b0, 16'hffff, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 32'hffff_ffff},
        1'b1, NoReport},
      // Connected and idle at time zero: only the presence flag.
      '{'{1'b1, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 32'd0},
        1'b1, '{1'b1, 16'h0, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0}},
      // Every button pressed after more than the interval: rise and repeat together.
      '{'{1'b1, 16'hffff, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 32'd16},
        1'b1, '{1'b1, 16'hffff, 16'hffff, 16'h0, 16'hffff, 8'h0, 8'h0, 8'h0, 8'h0}},
      // Still held, exactly one interval later: no repeat yet.
      '{'{1'b1, 16'hffff, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 32'd31},
        1'b1, '{1'b1, 16'hffff, 16'h0, 16'h0, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0}},
      // All released.
      '{'{1'b1, 16'h0000, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000, 32'd32},
        1'b1, '{1'b1, 16'h0, 16'h0, 16'hffff, 16'h0, 8'h0, 8'h0, 8'h0, 8'h0}},
      // Left stick fully up: d-pad up and the left stick's up direction.
      '{'{1'b1, 16'h0000, 16'sh0000, 16'sh7fff, 16'sh0000, 16'sh0000, 32'd100},
        1'b1, '{1'b1, 16'h0001, 16'h0001, 16'h0, 16'h0001, 8'h01, 8'h01, 8'h0, 8'h01}},
      // Left stick fully down, right stick fully right.
      '{'{1'b1, 16'h0000, 16'sh0000, 16'sh8000, 16'sh7fff, 16'sh0000, 32'd101},
        1'b1, '{1'b1, 16'h0002, 16'h0002, 16'h0001, 16'h0, 8'h82, 8'h82, 8'h01, 8'h82}},
      // The remaining directions of both sticks.
      '{'{1'b1, 16'h0000, 16'sh8000, 16'sh0000, 16'sh0000, 16'sh7fff, 32'd102},
        1'b0, NoReport},
      '{'{1'b1, 16'h0000, 16'sh7fff, 16'sh0000, 16'sh0000, 16'sh8000, 32'd103},
        1'b0, NoReport},
      '{'{1'b1, 16'h0000, 16'sh0000, 16'sh0000, 16'sh8000, 16'sh0000, 32'd104},
        1'b0, NoReport},
      // Exact diagonals on both sticks: no direction, but the d-pad still sees two bits.
      '{'{1'b1, 16'h0000, 16'sd20000, 16'sd20000, 16'sh8000, 16'sh8000, 32'd200},
        1'b0, NoReport},
      // Dominant axis at the threshold on the left, one above it on the right.
      '{'{1'b1, 16'h0000, 16'sd3276, 16'sd0, 16'sd0, 16'sd3277, 32'd201},
        1'b0, NoReport},
      // Both axes exactly on the dead zone.
      '{'{1'b1, 16'h0000, 16'sd7849, -16'sd7849, 16'sd0, 16'sd0, 32'd202},
        1'b0, NoReport},
      // Left x one inside the dead zone, left y well inside it.
      '{'{1'b1, 16'h0000, -16'sd7848, 16'sd7000, 16'sd0, 16'sd0, 32'd203},
        1'b0, NoReport},
      // Disconnected in the middle of activity: zero report, history kept.
      '{'{1'b0, 16'haaaa, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 32'd300},
        1'b1, NoReport},
      // Time close to the top of its range, then wrapping through zero.
      '{'{1'b1, 16'h5555, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hffff_fff0},
        1'b0, NoReport},
      '{'{1'b1, 16'haaaa, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'hffff_ffff},
        1'b0, NoReport},
      '{'{1'b1, 16'haaaa, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h0000_0005},
        1'b0, NoReport},
      '{'{1'b1, 16'hffff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 32'h0000_0006},
        1'b0, NoReport},
      '{'{1'b1, 16'h0000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h7fff_ffff},
        1'b0, NoReport}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [gerq_pkg::CsrIndexW-1:0] csr_index = gerq_pkg::CSR_DEAD_ZONE;
   logic [gerq_pkg::CsrDataW-1:0]  csr_wdata = '0;

   gerq_req_if req_chan ();
   gerq_rsp_if rsp_chan ();

   gamepad_edge_repeat_qualifier uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------------------------
   // Predictor state: a private copy of the registers and of the edge and repeat history.
   // ------------------------------------------------------------------------------------
   logic [gerq_pkg::DeadZoneW-1:0]  dead_zone_cfg       = gerq_pkg::DeadZoneReset;
   logic [gerq_pkg::IntervalW-1:0]  repeat_interval_cfg = gerq_pkg::IntervalReset;
   logic [gerq_pkg::ThresholdW-1:0] stick_threshold_cfg = gerq_pkg::ThresholdReset;

   logic [gerq_pkg::ButtonW-1:0]  held_word_before = '0;
   logic [gerq_pkg::TimeW-1:0]    word_repeat_at   = '0;
   logic [gerq_pkg::DirSlots-1:0] dirs_before      = '0;
   logic [gerq_pkg::TimeW-1:0]    dir_repeat_at [gerq_pkg::DirSlots];

   initial begin
      for (int d = 0; d < gerq_pkg::DirSlots; d++) begin
         dir_repeat_at[d] = '0;
      end
   end

   report_type awaited_reports [$];
   int         failures = 0;

   // The report typed into the current directed row, if it has one.
   logic       typed_row_active = 1'b0;
   report_type typed_row_report = '0;

   // Sender and receiver idling, in percent of cycles, set per phase.
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   int long_holds_asked = 0;
   int long_holds_done = 0;

   // Random stimulus memory, so that buttons stay held and time mostly moves forward.
   logic [gerq_pkg::TimeW-1:0]   pad_clock_ms = '0;
   logic [gerq_pkg::ButtonW-1:0] pad_buttons = '0;

   // Direction of one stick: its dominant axis, once past the threshold. A tie between the
   // axes is an exact diagonal and gives nothing.
   function automatic logic [gerq_pkg::DirsPerStick-1:0] stick_direction(
      input logic signed [gerq_pkg::AxisW-1:0] x, input logic signed [gerq_pkg::AxisW-1:0] y);
      int xi, yi, ax, ay, peak;
      logic [gerq_pkg::DirsPerStick-1:0] dir;
      xi = x;
      yi = y;
      ax = (xi < 0) ? -xi : xi;
      ay = (yi < 0) ? -yi : yi;
      peak = (ax > ay) ? ax : ay;
      dir = '0;
      if (peak > int'(stick_threshold_cfg)) begin
         if (ay > ax) begin
            dir[(yi > 0) ? gerq_pkg::DirUp : gerq_pkg::DirDown] = 1'b1;
         end else if (ax > ay) begin
            dir[(xi > 0) ? gerq_pkg::DirRight : gerq_pkg::DirLeft] = 1'b1;
         end
      end
      return dir;
   endfunction

   // D-pad bits that the left stick adds to the button word; the vertical test wins over
   // nothing, each axis giving at most one bit.
   function automatic logic [gerq_pkg::ButtonW-1:0] dpad_from_stick(
      input logic signed [gerq_pkg::AxisW-1:0] x, input logic signed [gerq_pkg::AxisW-1:0] y);
      int xi, yi, zone;
      logic [gerq_pkg::ButtonW-1:0] pad;
      xi = x;
      yi = y;
      zone = int'(dead_zone_cfg);
      pad = '0;
      if (yi >= zone) begin
         pad |= gerq_pkg::PadUp;
      end else if (yi <= -zone) begin
         pad |= gerq_pkg::PadDown;
      end
      if (xi <= -zone) begin
         pad |= gerq_pkg::PadLeft;
      end else if (xi >= zone) begin
         pad |= gerq_pkg::PadRight;
      end
      return pad;
   endfunction

   // Works out the report for one accepted poll and moves the history on.
   function automatic report_type qualify_poll(input poll_type poll);
      report_type report;
      logic [gerq_pkg::DirSlots-1:0] dirs;
      logic [gerq_pkg::DirSlots-1:0] pulses;
      logic [gerq_pkg::ButtonW-1:0]  word;
      logic [gerq_pkg::TimeW-1:0]    elapsed;
      report = '0;
      if (!poll.connected) begin
         return report;
      end
      dirs = {stick_direction(poll.right_x, poll.right_y),
              stick_direction(poll.left_x, poll.left_y)};
      pulses = '0;
      for (int d = 0; d < gerq_pkg::DirSlots; d++) begin
         elapsed = poll.now_ms - dir_repeat_at[d];
         if (dirs[d] && elapsed > {16'b0, repeat_interval_cfg}) begin
            dir_repeat_at[d] = poll.now_ms;
            pulses[d] = 1'b1;
         end
      end
      word = poll.buttons | dpad_from_stick(poll.left_x, poll.left_y);
      elapsed = poll.now_ms - word_repeat_at;
      if (word != '0 && elapsed > {16'b0, repeat_interval_cfg}) begin
         word_repeat_at = poll.now_ms;
         report.button_repeat = word;
      end
      report.pad_present  = 1'b1;
      report.button_press = word;
      report.button_rise  = word & ~held_word_before;
      report.button_fall  = ~word & held_word_before;
      report.stick_press  = dirs;
      report.stick_rise   = dirs & ~dirs_before;
      report.stick_fall   = ~dirs & dirs_before;
      report.stick_repeat = pulses;
      held_word_before = word;
      dirs_before = dirs;
      return report;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         failures++;
      end
   endtask

   // ------------------------------------------------------------------------------------
   // Monitor: both channels sampled at the rising edge. A report is compared before the
   // poll of the same edge is predicted; a poll passes the input and result registers
   // before its report appears, so they never belong together anyway.
   // ------------------------------------------------------------------------------------
   always @(posedge clock) begin
      report_type got;
      report_type want;
      report_type predicted;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.pad_present, rsp_chan.button_press, rsp_chan.button_rise,
                    rsp_chan.button_fall, rsp_chan.button_repeat, rsp_chan.stick_press,
                    rsp_chan.stick_rise, rsp_chan.stick_fall, rsp_chan.stick_repeat};
            if (awaited_reports.size() == 0) begin
               $error("report transaction arrived with none outstanding");
               failures++;
            end else begin
               want = awaited_reports.pop_front();
               check_field("pad_present", want.pad_present, got.pad_present);
               check_field("button_press", want.button_press, got.button_press);
               check_field("button_rise", want.button_rise, got.button_rise);
               check_field("button_fall", want.button_fall, got.button_fall);
               check_field("button_repeat", want.button_repeat, got.button_repeat);
               check_field("stick_press", want.stick_press, got.stick_press);
               check_field("stick_rise", want.stick_rise, got.stick_rise);
               check_field("stick_fall", want.stick_fall, got.stick_fall);
               check_field("stick_repeat", want.stick_repeat, got.stick_repeat);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            // The predictor runs on every poll so that its history stays in step, even
            // where the directed table supplies the report itself.
            predicted = qualify_poll('{req_chan.connected, req_chan.buttons, req_chan.left_x,
                                       req_chan.left_y, req_chan.right_x, req_chan.right_y,
                                       req_chan.now_ms});
            awaited_reports.push_back(typed_row_active ? typed_row_report : predicted);
         end
      end
   end

   // Watchdog: ends the run once too many cycles pass without any transaction.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
         $display("Verification failed");
         $finish;
      end
   end

   // Receiver: stalls at random at the phase's rate, and on request holds off for a long
   // stretch so that both pipeline stages fill and the request channel backs up.
   int hold_left = 0;

   initial begin
      rsp_chan.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left--;
         rsp_chan.ready = 1'b0;
      end else if (long_holds_done != long_holds_asked) begin
         long_holds_done++;
         hold_left = LongHoldCycles - 1;
         rsp_chan.ready = 1'b0;
      end else begin
         rsp_chan.ready = ($urandom_range(1, 100) > receiver_stall_pct);
      end
   end

   // ------------------------------------------------------------------------------------
   // Stimulus tasks. Inputs change on the falling edge only.
   // ------------------------------------------------------------------------------------
   task automatic send_poll(input poll_type poll, input logic typed, input report_type report);
      while ($urandom_range(1, 100) <= sender_idle_pct) begin
         @(negedge clock);
         req_chan.valid = 1'b0;
      end
      @(negedge clock);
      req_chan.connected = poll.connected;
      req_chan.buttons   = poll.buttons;
      req_chan.left_x    = poll.left_x;
      req_chan.left_y    = poll.left_y;
      req_chan.right_x   = poll.right_x;
      req_chan.right_y   = poll.right_y;
      req_chan.now_ms    = poll.now_ms;
      req_chan.valid     = 1'b1;
      typed_row_active   = typed;
      typed_row_report   = report;
      do begin
         @(posedge clock);
      end while (!req_chan.ready);
   endtask

   // Stops offering polls and waits for every outstanding report.
   task automatic drain_reports();
      @(negedge clock);
      req_chan.valid = 1'b0;
      typed_row_active = 1'b0;
      while (awaited_reports.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic write_register(input gerq_pkg::csr_index_type index,
                                 input logic [gerq_pkg::CsrDataW-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = index;
      csr_wdata = value;
      case (index)
         gerq_pkg::CSR_DEAD_ZONE:
            dead_zone_cfg = value[gerq_pkg::DeadZoneW-1:0];
         gerq_pkg::CSR_REPEAT_INTERVAL:
            repeat_interval_cfg = value[gerq_pkg::IntervalW-1:0];
         gerq_pkg::CSR_STICK_THRESHOLD:
            stick_threshold_cfg = value[gerq_pkg::ThresholdW-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(input logic [gerq_pkg::CsrDataW-1:0] zone,
                                input logic [gerq_pkg::CsrDataW-1:0] interval,
                                input logic [gerq_pkg::CsrDataW-1:0] threshold);
      write_register(gerq_pkg::CSR_DEAD_ZONE, zone);
      write_register(gerq_pkg::CSR_REPEAT_INTERVAL, interval);
      write_register(gerq_pkg::CSR_STICK_THRESHOLD, threshold);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // One axis value, weighted towards the places where behaviour changes: the extremes,
   // either side of the dead zone and of the stick threshold, and the rest position.
   function automatic logic signed [gerq_pkg::AxisW-1:0] random_axis();
      int magnitude;
      case ($urandom_range(0, 9))
         0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         1, 2: magnitude = int'(dead_zone_cfg) + $urandom_range(0, 2) - 1;
         3, 4: magnitude = int'(stick_threshold_cfg) + $urandom_range(0, 2) - 1;
         5: magnitude = $urandom_range(0, 100);
         default: return gerq_pkg::AxisW'($urandom);
      endcase
      if (magnitude < 0) begin
         magnitude = 0;
      end else if (magnitude > 32767) begin
         magnitude = 32767;
      end
      return gerq_pkg::AxisW'($urandom_range(0, 1) ? -magnitude : magnitude);
   endfunction

   // A plausible next poll: buttons mostly held with the odd bit changing, time moving
   // forward by about the repeat interval, now and then a jump anywhere in the time range.
   function automatic poll_type next_random_poll();
      poll_type poll;
      poll.connected = ($urandom_range(0, 9) != 0);
      case ($urandom_range(0, 9))
         0: pad_buttons = gerq_pkg::ButtonW'($urandom);
         1: pad_buttons = '0;
         2, 3, 4: pad_buttons ^= gerq_pkg::ButtonW'(1)
                                 << $urandom_range(0, gerq_pkg::ButtonW - 1);
         default: ;
      endcase
      poll.buttons = pad_buttons;
      if ($urandom_range(0, 29) == 0) begin
         pad_clock_ms = $urandom;
      end else begin
         pad_clock_ms += $urandom_range(0, int'(repeat_interval_cfg) * 3 / 2 + 3);
      end
      poll.now_ms = pad_clock_ms;
      poll.left_x  = random_axis();
      poll.left_y  = random_axis();
      poll.right_x = random_axis();
      poll.right_y = random_axis();
      // Now and then an exact diagonal on one stick.
      if ($urandom_range(0, 7) == 0) begin
         poll.left_y = $urandom_range(0, 1) ? poll.left_x : -poll.left_x;
      end
      if ($urandom_range(0, 7) == 0) begin
         poll.right_x = $urandom_range(0, 1) ? poll.right_y : -poll.right_y;
      end
      return poll;
   endfunction

   // ------------------------------------------------------------------------------------
   // Run sequence: reset, directed table, then phases of random polls, each phase under
   // its own register setting and idling pattern.
   // ------------------------------------------------------------------------------------
   initial begin
      req_chan.valid     = 1'b0;
      req_chan.connected = 1'b0;
      req_chan.buttons   = '0;
      req_chan.left_x    = '0;
      req_chan.left_y    = '0;
      req_chan.right_x   = '0;
      req_chan.right_y   = '0;
      req_chan.now_ms    = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int phase = 0; phase < PhaseCount; phase++) begin
         // The sender pauses here until every report is in, so that the registers change
         // only while the block is empty.
         drain_reports();
         case (phase)
            0: ;
            1: apply_setting(16'd1, 16'd0, 16'd0);
            2: apply_setting(16'd32767, 16'd65535, 16'd32768);
            3: apply_setting(gerq_pkg::CsrDataW'($urandom_range(1, 32767)),
                             gerq_pkg::CsrDataW'($urandom_range(0, 300)),
                             gerq_pkg::CsrDataW'($urandom_range(0, 32768)));
            4: apply_setting(gerq_pkg::CsrDataW'(gerq_pkg::DeadZoneReset),
                             gerq_pkg::IntervalReset, gerq_pkg::ThresholdReset);
            5: apply_setting(gerq_pkg::CsrDataW'($urandom_range(1, 32767)),
                             gerq_pkg::CsrDataW'($urandom_range(0, 65535)),
                             gerq_pkg::CsrDataW'($urandom_range(0, 32768)));
            6: apply_setting(16'd100, 16'd1, 16'd32767);
            default: apply_setting(gerq_pkg::CsrDataW'($urandom_range(1, 32767)),
                                   gerq_pkg::CsrDataW'($urandom_range(0, 40)),
                                   gerq_pkg::CsrDataW'($urandom_range(0, 32768)));
         endcase

         case (phase % 4)
            0: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct = 51;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct = 0;
               receiver_stall_pct = 51;
            end
            default: begin
               sender_idle_pct = 8;
               receiver_stall_pct = 8;
            end
         endcase

         if (phase == 0) begin
            foreach (DirectedRows[row]) begin
               send_poll(DirectedRows[row].poll, DirectedRows[row].typed,
                         DirectedRows[row].report);
            end
            pad_clock_ms = DirectedRows[$size(DirectedRows) - 1].poll.now_ms;
         end

         // One long receiver hold per phase while polls keep coming.
         long_holds_asked++;
         for (int n = 0; n < RandomPollsPerPhase; n++) begin
            send_poll(next_random_poll(), 1'b0, NoReport);
         end
      end

      drain_reports();
      repeat (TailCycles) @(posedge clock);
      if (failures == 0 && awaited_reports.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
